>>> hdl/mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Field widths, stream packing and the command and status groups passed
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int BASE_W    = 31;
    localparam int EXP_W     = 31;
    localparam int CFG_W     = 16;
    localparam int OUT_W     = 16;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture a new beat and start the base reduction
        logic div_step;   // one bit of the base reduction
        logic mul_start;  // clear the accumulator and load the multiplier operand
        logic sel_sqr;    // operand for mul_start: base (square) or product (multiply)
        logic mul_step;   // one bit of the modular multiplication
        logic wr_prod;    // store the multiplication result as the running product
        logic wr_base;    // store the multiplication result as the new base
        logic exp_shift;  // move to the next exponent bit
        logic out_load;   // capture the result into the output register
    } mexp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_small;  // modulus is zero or one
        logic div_last;   // final reduction step this cycle
        logic mul_last;   // final multiplication step this cycle
        logic exp_zero;   // no exponent bits left to process
        logic exp_bit;    // current exponent bit
    } mexp_status_t;

endpackage

>>> hdl/mexp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Holds the modulus register, the bit-serial base reduction, the shared
// shift-and-add modular multiplier, the exponent shifter and the output register.
// ----------------------------------------------------------------------------
module mexp_dp #(
    parameter int EXP_BITS = 31,
    parameter int MOD_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [mexp_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic [mexp_pkg::BASE_W-1:0]    in_base,
    input  logic [mexp_pkg::EXP_W-1:0]     in_exp,
    input  mexp_pkg::mexp_cmd_t            cmd,
    output mexp_pkg::mexp_status_t         status,
    output logic [mexp_pkg::OUT_W-1:0]     result
);
    import mexp_pkg::*;

    localparam int MW  = (MOD_BITS < CFG_W) ? MOD_BITS : CFG_W;
    localparam int EW  = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
    localparam int DCW = $clog2(BASE_W);
    localparam int MCW = (MW > 1) ? $clog2(MW) : 1;

    logic [CFG_W-1:0]  modulus_reg;
    logic [MW-1:0]     base_reg;
    logic [BASE_W-1:0] bsh_reg;
    logic [EW-1:0]     exp_reg;
    logic [MW-1:0]     prod_reg;
    logic [MW-1:0]     acc_reg;
    logic [MW-1:0]     mop_reg;
    logic [DCW-1:0]    div_cnt_reg;
    logic [MCW-1:0]    mul_cnt_reg;
    logic [OUT_W-1:0]  out_reg;

    logic [MW-1:0] m;
    logic [MW:0]   m_ext;
    logic [MW:0]   div_try;
    logic [MW:0]   div_red;
    logic [MW:0]   dbl_try;
    logic [MW:0]   dbl_red;
    logic [MW:0]   add_try;
    logic [MW:0]   add_red;
    logic [MW-1:0] mul_res;

    assign m     = modulus_reg[MW-1:0];
    assign m_ext = {1'b0, m};

    // Restoring reduction: one dividend bit per cycle, remainder kept below m.
    assign div_try = {base_reg, bsh_reg[BASE_W-1]};
    assign div_red = (div_try >= m_ext) ? div_try - m_ext : div_try;

    // Interleaved multiply: double the accumulator, then add the base if the
    // operand bit is set, reducing after each add. Both terms stay below m.
    assign dbl_try = {acc_reg, 1'b0};
    assign dbl_red = (dbl_try >= m_ext) ? dbl_try - m_ext : dbl_try;
    assign add_try = {1'b0, dbl_red[MW-1:0]} + {1'b0, base_reg};
    assign add_red = (add_try >= m_ext) ? add_try - m_ext : add_try;
    assign mul_res = mop_reg[MW-1] ? add_red[MW-1:0] : dbl_red[MW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            modulus_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_reg    <= '0;
            bsh_reg     <= in_base;
            exp_reg     <= in_exp[EW-1:0];
            prod_reg    <= MW'(1);
            div_cnt_reg <= DCW'(BASE_W - 1);
        end
        if (cmd.div_step) begin
            base_reg    <= div_red[MW-1:0];
            bsh_reg     <= {bsh_reg[BASE_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
        if (cmd.mul_start) begin
            acc_reg     <= '0;
            mop_reg     <= cmd.sel_sqr ? base_reg : prod_reg;
            mul_cnt_reg <= MCW'(MW - 1);
        end else if (cmd.mul_step) begin
            acc_reg     <= mul_res;
            mop_reg     <= {mop_reg[MW-2:0], 1'b0};
            mul_cnt_reg <= mul_cnt_reg - MCW'(1);
        end
        if (cmd.wr_prod) begin
            prod_reg <= mul_res;
        end
        if (cmd.wr_base) begin
            base_reg <= mul_res;
        end
        if (cmd.exp_shift) begin
            exp_reg <= exp_reg >> 1;
        end
        if (cmd.out_load) begin
            out_reg <= status.mod_small ? '0 : OUT_W'(prod_reg);
        end
    end

    assign status.mod_small = (m <= MW'(1));
    assign status.div_last  = (div_cnt_reg == '0);
    assign status.mul_last  = (mul_cnt_reg == '0);
    assign status.exp_zero  = (exp_reg == '0);
    assign status.exp_bit   = exp_reg[0];

    assign result = out_reg;

endmodule

>>> hdl/mexp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences reduction, multiply and square steps per exponent bit and owns
// the stream handshakes.
// ----------------------------------------------------------------------------
module mexp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  mexp_pkg::mexp_status_t status,
    output mexp_pkg::mexp_cmd_t    cmd
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_BIT,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
            end
            ST_REDUCE: begin
                cmd.div_step = 1'b1;
            end
            ST_BIT: begin
                cmd.mul_start = !status.exp_zero;
                cmd.sel_sqr   = !status.exp_bit;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                // The square of the same base follows straight on.
                if (status.mul_last) begin
                    cmd.wr_prod   = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.sel_sqr   = 1'b1;
                end
            end
            ST_SQR: begin
                cmd.mul_step = 1'b1;
                if (status.mul_last) begin
                    cmd.wr_base   = 1'b1;
                    cmd.exp_shift = 1'b1;
                end
            end
            ST_DONE: begin
                cmd.out_load = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A new result replaces one that is taken at the same edge.
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= status.mod_small ? ST_DONE : ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    if (status.div_last) begin
                        state_reg <= ST_BIT;
                    end
                end
                ST_BIT: begin
                    if (status.exp_zero) begin
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= status.exp_bit ? ST_MUL : ST_SQR;
                    end
                end
                ST_MUL: begin
                    if (status.mul_last) begin
                        state_reg <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    if (status.mul_last) begin
                        state_reg <= ST_BIT;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation
// Raises a base to an exponent modulo a configured modulus by right-to-left
// binary square and multiply on one shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Usage: write the modulus through cfg_wr_en/cfg_wr_data while the block is
// idle; it resets to one, which gives a result of zero for every beat.
// Each input beat carries a base and an exponent; each produces exactly one
// output beat holding base^exponent mod modulus.
// One beat is worked on at a time. How long a beat takes grows with
// MW = min(MOD_BITS, 16) and with the position of the highest set exponent
// bit. The base is first reduced modulo the modulus by the restoring
// reduction; then each exponent bit up to the highest set one gets a
// multiply if it is set and always a square, both on the shared multiplier,
// which retires one operand bit per cycle. A modulus of zero or one skips
// both the reduction and the multiplication.
// A finished result sits in the output register while the next beat is
// accepted and computed; the block only waits when a second result is ready
// and the first has still not been taken. Reset is synchronous and active
// low; it clears the handshake state and restores the modulus to one.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int EXP_BITS = 31,
    parameter int MOD_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mexp_pkg::CFG_W-1:0]       cfg_wr_data,  // modulus
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mexp_pkg::S_TDATA_W-1:0]   s_tdata,      // base_value, exponent
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mexp_pkg::M_TDATA_W-1:0]   m_tdata       // power_mod
);
    import mexp_pkg::*;

    mexp_cmd_t    cmd;
    mexp_status_t status;
    logic [OUT_W-1:0] result;

    mexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mexp_dp #(
        .EXP_BITS (EXP_BITS),
        .MOD_BITS (MOD_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_base     (s_tdata[BASE_W-1:0]),
        .in_exp      (s_tdata[BASE_W +: EXP_W]),
        .cmd         (cmd),
        .status      (status),
        .result      (result)
    );

    assign m_tdata = M_TDATA_W'(result);

endmodule

>>> hdl/mexp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation port checker
// Watches the top-level ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
module mexp_chk (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mexp_pkg::M_TDATA_W-1:0]   m_tdata
);
    import mexp_pkg::*;

    // A stalled result beat must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Only one beat is in work at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a beat is in work");

    // A result is launched only as the block returns to idle.
    a_launch_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result launched while still busy");

    // Leaving reset, no result is pending and the input side is open.
    a_reset_state: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_tvalid && s_tready)
        else $error("wrong handshake state after reset");

endmodule

bind modular_exponentiation mexp_chk u_mexp_chk (.*);
